// ===== hdl/tcpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_pkg
// Shared types, codes and default sizes of the two-class priority dispatcher.
// ----------------------------------------------------------------------------
package tcpd_pkg;

  // Default pool and queue sizes
  localparam int DEF_NUM_SERVERS = 5;
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_ID_BITS     = 10;

  // Kind of work the front end hands to the back end
  typedef enum logic [1:0] {
    OP_ARRIVE_LOW  = 2'd0,
    OP_ARRIVE_HIGH = 2'd1,
    OP_FINISH      = 2'd2
  } tcpd_kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_DROPPED     = 2'd1,
    ST_IDLE_FINISH = 2'd2
  } tcpd_status_t;

  // Classified command as it travels from front to back
  typedef struct packed {
    tcpd_kind_t kind;
    logic       srv_ok;   // server index lies inside the pool
  } tcpd_op_t;

endpackage
`default_nettype wire

// ===== hdl/tcpd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_front
// Accepts input transfers, classifies each command and holds it in a
// two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module tcpd_front #(
  parameter  int NUM_SERVERS = tcpd_pkg::DEF_NUM_SERVERS,
  parameter  int ID_BITS     = tcpd_pkg::DEF_ID_BITS,
  localparam int SRV_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [ID_BITS-1:0]   requester_id,
  input  logic                 high_class,
  input  logic [SRV_W-1:0]     server_index,
  output logic                 q_valid,
  output tcpd_pkg::tcpd_op_t   q_op,
  output logic [ID_BITS-1:0]   q_id,
  output logic [SRV_W-1:0]     q_idx,
  input  logic                 q_take
);
  import tcpd_pkg::*;

  tcpd_op_t           new_op;
  logic               push;
  logic               to_head;
  logic [1:0]         cnt;
  tcpd_op_t           s0_op, s1_op;
  logic [ID_BITS-1:0] s0_id, s1_id;
  logic [SRV_W-1:0]   s0_idx, s1_idx;

  // Classify the incoming command
  always_comb begin
    if (command) begin
      new_op.kind = OP_FINISH;
    end else if (high_class) begin
      new_op.kind = OP_ARRIVE_HIGH;
    end else begin
      new_op.kind = OP_ARRIVE_LOW;
    end
    new_op.srv_ok = ({1'b0, server_index} < (SRV_W + 1)'(NUM_SERVERS));
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign to_head  = push && ((cnt == 2'd0) || (cnt == 2'd1 && q_take));

  // Track queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !q_take) begin
      cnt <= cnt + 2'd1;
    end else if (q_take && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Shift entries toward the head and write new transfers behind them
  always_ff @(posedge clk) begin
    if (to_head) begin
      s0_op  <= new_op;
      s0_id  <= requester_id;
      s0_idx <= server_index;
    end else if (q_take) begin
      s0_op  <= s1_op;
      s0_id  <= s1_id;
      s0_idx <= s1_idx;
    end
    if (push && !to_head) begin
      s1_op  <= new_op;
      s1_id  <= requester_id;
      s1_idx <= server_index;
    end
  end

  assign q_valid = (cnt != 2'd0);
  assign q_op    = s0_op;
  assign q_id    = s0_id;
  assign q_idx   = s0_idx;

endmodule
`default_nettype wire

// ===== hdl/tcpd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_back
// Carries out one classified command: pushes into the high or low wait
// FIFO, frees a server, dispatches one waiter to the lowest free server and
// presents the result in an output register.
// ----------------------------------------------------------------------------
module tcpd_back #(
  parameter  int NUM_SERVERS = tcpd_pkg::DEF_NUM_SERVERS,
  parameter  int QUEUE_DEPTH = tcpd_pkg::DEF_QUEUE_DEPTH,
  parameter  int ID_BITS     = tcpd_pkg::DEF_ID_BITS,
  localparam int SRV_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
  localparam int FREE_W      = $clog2(NUM_SERVERS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  tcpd_pkg::tcpd_op_t   q_op,
  input  logic [ID_BITS-1:0]   q_id,
  input  logic [SRV_W-1:0]     q_idx,
  output logic                 q_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 dispatched,
  output logic [ID_BITS-1:0]   served_id,
  output logic [SRV_W-1:0]     assigned_server,
  output logic                 served_high,
  output logic [CNT_W-1:0]     high_count,
  output logic [CNT_W-1:0]     low_count,
  output logic [FREE_W-1:0]    free_servers,
  output logic [1:0]           status
);
  import tcpd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  logic [ID_BITS-1:0]     hi_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0]     lo_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0]     hi_rd, lo_rd;
  logic [PTR_W-1:0]       hi_head, hi_tail, lo_head, lo_tail, rd_addr;
  logic [CNT_W-1:0]       hi_cnt, lo_cnt;
  logic [NUM_SERVERS-1:0] busy;
  logic [FREE_W-1:0]      free_cnt;

  logic                   res_disp, res_high;
  logic [SRV_W-1:0]       res_srv;
  logic [CNT_W-1:0]       res_hcnt, res_lcnt;
  logic [FREE_W-1:0]      res_free;
  tcpd_status_t           res_status;

  logic                   exec;
  logic                   push_hi, push_lo, fin;
  logic                   hi_full, lo_full, hi_we, lo_we;
  logic                   srv_busy, free_req;
  logic [NUM_SERVERS-1:0] busy_a, busy_next;
  logic [CNT_W-1:0]       hi_cnt_a, lo_cnt_a, hi_cnt_next, lo_cnt_next;
  logic [SRV_W-1:0]       pick;
  logic                   any_free, disp, take_hi, take_lo;
  logic [FREE_W-1:0]      free_next;
  tcpd_status_t           status_c;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign exec   = (state == S_IDLE) && q_valid;
  assign q_take = exec;

  // Apply the command and decide the dispatch
  always_comb begin
    push_hi  = (q_op.kind == OP_ARRIVE_HIGH);
    push_lo  = (q_op.kind == OP_ARRIVE_LOW);
    fin      = (q_op.kind == OP_FINISH);
    hi_full  = (hi_cnt == CNT_W'(QUEUE_DEPTH));
    lo_full  = (lo_cnt == CNT_W'(QUEUE_DEPTH));
    hi_we    = push_hi && !hi_full;
    lo_we    = push_lo && !lo_full;
    srv_busy = q_op.srv_ok && busy[q_idx];
    free_req = fin && srv_busy;

    if ((push_hi && hi_full) || (push_lo && lo_full)) begin
      status_c = ST_DROPPED;
    end else if (fin && !srv_busy) begin
      status_c = ST_IDLE_FINISH;
    end else begin
      status_c = ST_OK;
    end

    busy_a   = free_req ? (busy & ~(NUM_SERVERS'(1) << q_idx)) : busy;
    hi_cnt_a = hi_cnt + CNT_W'(hi_we);
    lo_cnt_a = lo_cnt + CNT_W'(lo_we);

    // Find the lowest-numbered free server
    pick = '0;
    for (int i = NUM_SERVERS - 1; i >= 0; i--) begin
      if (!busy_a[i]) begin
        pick = SRV_W'(i);
      end
    end
    any_free = !(&busy_a);

    disp    = any_free && ((hi_cnt_a != '0) || (lo_cnt_a != '0));
    take_hi = disp && (hi_cnt_a != '0);
    take_lo = disp && !take_hi;

    hi_cnt_next = hi_cnt_a - CNT_W'(take_hi);
    lo_cnt_next = lo_cnt_a - CNT_W'(take_lo);
    busy_next   = disp ? (busy_a | (NUM_SERVERS'(1) << pick)) : busy_a;
    free_next   = free_cnt + FREE_W'(free_req) - FREE_W'(disp);
  end

  // Sequence execute, memory read and result hold
  always_comb begin
    case (state)
      S_IDLE:  state_next = q_valid ? S_READ : S_IDLE;
      S_READ:  state_next = S_HOLD;
      S_HOLD:  state_next = out_stall ? S_HOLD : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      hi_head  <= '0;
      hi_tail  <= '0;
      hi_cnt   <= '0;
      lo_head  <= '0;
      lo_tail  <= '0;
      lo_cnt   <= '0;
      busy     <= '0;
      free_cnt <= FREE_W'(NUM_SERVERS);
    end else begin
      state <= state_next;
      if (exec) begin
        hi_cnt   <= hi_cnt_next;
        lo_cnt   <= lo_cnt_next;
        busy     <= busy_next;
        free_cnt <= free_next;
        if (hi_we) begin
          hi_tail <= ptr_inc(hi_tail);
        end
        if (lo_we) begin
          lo_tail <= ptr_inc(lo_tail);
        end
        if (take_hi) begin
          hi_head <= ptr_inc(hi_head);
        end
        if (take_lo) begin
          lo_head <= ptr_inc(lo_head);
        end
      end
    end
  end

  // Capture the result fields known at execute time
  always_ff @(posedge clk) begin
    if (exec) begin
      res_disp   <= disp;
      res_high   <= take_hi;
      res_srv    <= disp ? pick : '0;
      res_hcnt   <= hi_cnt_next;
      res_lcnt   <= lo_cnt_next;
      res_free   <= free_next;
      res_status <= status_c;
      rd_addr    <= take_hi ? hi_head : lo_head;
    end
  end

  // High wait FIFO memory
  always_ff @(posedge clk) begin
    if (exec && hi_we) begin
      hi_mem[hi_tail] <= q_id;
    end
    if ((state == S_READ) && res_high) begin
      hi_rd <= hi_mem[rd_addr];
    end
  end

  // Low wait FIFO memory
  always_ff @(posedge clk) begin
    if (exec && lo_we) begin
      lo_mem[lo_tail] <= q_id;
    end
    if ((state == S_READ) && !res_high) begin
      lo_rd <= lo_mem[rd_addr];
    end
  end

  assign out_valid       = (state == S_HOLD);
  assign dispatched      = res_disp;
  assign served_id       = res_disp ? (res_high ? hi_rd : lo_rd) : '0;
  assign assigned_server = res_srv;
  assign served_high     = res_high;
  assign high_count      = res_hcnt;
  assign low_count       = res_lcnt;
  assign free_servers    = res_free;
  assign status          = res_status;

`ifndef SYNTHESIS
  a_free_matches_map: assert property (@(posedge clk) disable iff (rst)
    free_cnt == FREE_W'(NUM_SERVERS - $countones(busy)))
    else $error("free server count out of step with busy map");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (hi_cnt <= CNT_W'(QUEUE_DEPTH)) && (lo_cnt <= CNT_W'(QUEUE_DEPTH)))
    else $error("wait FIFO count beyond depth");

  a_dispatch_marks_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_disp |-> busy[res_srv])
    else $error("dispatched server is not marked busy");

  a_read_then_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_HOLD))
    else $error("memory read not followed by result hold");
`endif

endmodule
`default_nettype wire

// ===== hdl/two_class_priority_dispatcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_priority_dispatcher
// Strict-priority two-class wait queues feeding a pool of servers.
// ----------------------------------------------------------------------------
// Each input transfer is either an arrival (pushed to the high or low wait
// FIFO) or a finish (frees the named server); after it, at most one waiter is
// dispatched, high class first, to the lowest-numbered free server, and one
// result transfer follows. A two-entry front queue accepts and classifies
// transfers while the back end works; the back end takes each item through
// execute, registered FIFO memory read and result register, and takes no new
// item until that result has left, which waits while out_stall is high. A
// push into a full FIFO is dropped with status 1; a finish for an idle or
// nonexistent server changes nothing and gives status 2.
module two_class_priority_dispatcher #(
  parameter  int NUM_SERVERS = tcpd_pkg::DEF_NUM_SERVERS,
  parameter  int QUEUE_DEPTH = tcpd_pkg::DEF_QUEUE_DEPTH,
  parameter  int ID_BITS     = tcpd_pkg::DEF_ID_BITS,
  localparam int SRV_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
  localparam int FREE_W      = $clog2(NUM_SERVERS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [ID_BITS-1:0]  requester_id,
  input  logic                high_class,
  input  logic [SRV_W-1:0]    server_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                dispatched,
  output logic [ID_BITS-1:0]  served_id,
  output logic [SRV_W-1:0]    assigned_server,
  output logic                served_high,
  output logic [CNT_W-1:0]    high_count,
  output logic [CNT_W-1:0]    low_count,
  output logic [FREE_W-1:0]   free_servers,
  output logic [1:0]          status
);
  import tcpd_pkg::*;

  logic               q_valid;
  logic               q_take;
  tcpd_op_t           q_op;
  logic [ID_BITS-1:0] q_id;
  logic [SRV_W-1:0]   q_idx;

  // Accept and classify transfers
  tcpd_front #(
    .NUM_SERVERS (NUM_SERVERS),
    .ID_BITS     (ID_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .requester_id (requester_id),
    .high_class   (high_class),
    .server_index (server_index),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_id         (q_id),
    .q_idx        (q_idx),
    .q_take       (q_take)
  );

  // Execute commands and dispatch waiters
  tcpd_back #(
    .NUM_SERVERS (NUM_SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_id            (q_id),
    .q_idx           (q_idx),
    .q_take          (q_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .dispatched      (dispatched),
    .served_id       (served_id),
    .assigned_server (assigned_server),
    .served_high     (served_high),
    .high_count      (high_count),
    .low_count       (low_count),
    .free_servers    (free_servers),
    .status          (status)
  );

endmodule
`default_nettype wire
